FILE: rtl/core/tlbcr_pkg.sv
// Shared constants, request codes and controller/datapath types for the clock-replacement TLB.
package tlbcr_pkg;

   localparam int ENTRIES    = 64;
   localparam int SLOT_BITS  = $clog2(ENTRIES);
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);
   localparam int PAGE_BITS  = 20;
   localparam int FRAME_BITS = 20;
   localparam int TYPE_BITS  = 2;

   localparam logic [TYPE_BITS-1:0] REQ_LOOKUP = 2'd0;
   localparam logic [TYPE_BITS-1:0] REQ_INSERT = 2'd1;
   localparam logic [TYPE_BITS-1:0] REQ_INVAL  = 2'd2;

   typedef struct packed {
      logic capture;     // latch the incoming word
      logic match;       // register the CAM match vector
      logic pick;        // encode slot and hit flags
      logic set_refs;    // mark every lookup match referenced
      logic sweep;       // one clock hand step
      logic read_frame;  // read frame memory at the chosen slot
      logic commit;      // write back insert / invalidate
      logic load_rsp;    // move result into the output register
   } cmd_type;

   typedef struct packed {
      logic [TYPE_BITS-1:0] req_type;
      logic                 any_match;
      logic                 free_avail;
      logic                 ref_at_hand;
   } status_type;

endpackage

FILE: rtl/core/tlbcr_req_if.sv
// Request channel: valid/ready handshake carrying one TLB request word.
interface tlbcr_req_if;
   logic                                valid;
   logic                                ready;
   logic [tlbcr_pkg::TYPE_BITS-1:0]     req_type;
   logic [tlbcr_pkg::PAGE_BITS-1:0]     page_number;
   logic [tlbcr_pkg::FRAME_BITS-1:0]    frame_number;

   modport source (output valid, req_type, page_number, frame_number, input ready);
   modport sink (input valid, req_type, page_number, frame_number, output ready);
endinterface

FILE: rtl/core/tlbcr_rsp_if.sv
// Response channel: valid/ready handshake carrying one TLB result word.
interface tlbcr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                hit;
   logic [tlbcr_pkg::FRAME_BITS-1:0]    found_frame;
   logic [tlbcr_pkg::SLOT_BITS-1:0]     slot_used;
   logic                                replaced;

   modport source (output valid, hit, found_frame, slot_used, replaced, input ready);
   modport sink (input valid, hit, found_frame, slot_used, replaced, output ready);
endinterface

FILE: rtl/core/tlb_clock_replacement_unit.sv
// Top level of the fully associative TLB with clock (second chance) replacement.
//
//   channel  dir  handshake      word
//   req      in   valid/ready    req_type, page_number, frame_number
//   rsp      out  valid/ready    hit, found_frame, slot_used, replaced
//
// One request at a time. After acceptance come match and pick; a lookup miss or an
// unknown type then goes to the response, a lookup hit reads the frame, and invalidate
// and insert into a free slot commit; a full-table insert first takes k = 1..ENTRIES+1
// clock hand steps (one reference bit examined per cycle), then commits. Requests are
// accepted only in the idle state. Synchronous reset clears valid and reference bits and
// the hand, and sets the free count to ENTRIES.
// A result waiting in the output register holds off only the next result, not acceptance.
module tlb_clock_replacement_unit (
   input  logic          clock,
   input  logic          reset,
   tlbcr_req_if.sink     req,
   tlbcr_rsp_if.source   rsp
);

   tlbcr_pkg::cmd_type    cmd;
   tlbcr_pkg::status_type status;

   tlbcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tlbcr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req.req_type),
      .page_number     (req.page_number),
      .frame_number    (req.frame_number),
      .rsp_hit         (rsp.hit),
      .rsp_found_frame (rsp.found_frame),
      .rsp_slot_used   (rsp.slot_used),
      .rsp_replaced    (rsp.replaced)
   );

endmodule

FILE: rtl/core/tlbcr_datapath.sv
// TLB datapath: entry CAM, frame memory, clock hand, free count and result registers.
module tlbcr_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  tlbcr_pkg::cmd_type                  cmd,
   output tlbcr_pkg::status_type               status,
   input  logic [tlbcr_pkg::TYPE_BITS-1:0]     req_type,
   input  logic [tlbcr_pkg::PAGE_BITS-1:0]     page_number,
   input  logic [tlbcr_pkg::FRAME_BITS-1:0]    frame_number,
   output logic                                rsp_hit,
   output logic [tlbcr_pkg::FRAME_BITS-1:0]    rsp_found_frame,
   output logic [tlbcr_pkg::SLOT_BITS-1:0]     rsp_slot_used,
   output logic                                rsp_replaced
);

   function automatic logic [tlbcr_pkg::SLOT_BITS-1:0] lowest_set(
      input logic [tlbcr_pkg::ENTRIES-1:0] v);
      logic [tlbcr_pkg::SLOT_BITS-1:0] idx;
      idx = '0;
      for (int i = tlbcr_pkg::ENTRIES - 1; i >= 0; i--) begin
         if (v[i]) idx = tlbcr_pkg::SLOT_BITS'(i);
      end
      return idx;
   endfunction

   function automatic logic [tlbcr_pkg::SLOT_BITS-1:0] highest_set(
      input logic [tlbcr_pkg::ENTRIES-1:0] v);
      logic [tlbcr_pkg::SLOT_BITS-1:0] idx;
      idx = '0;
      for (int i = 0; i < tlbcr_pkg::ENTRIES; i++) begin
         if (v[i]) idx = tlbcr_pkg::SLOT_BITS'(i);
      end
      return idx;
   endfunction

   // latched request word
   logic [tlbcr_pkg::TYPE_BITS-1:0]    type_ff;
   logic [tlbcr_pkg::PAGE_BITS-1:0]    page_req_ff;
   logic [tlbcr_pkg::FRAME_BITS-1:0]   frame_req_ff;

   // entry state
   logic [tlbcr_pkg::ENTRIES-1:0]      valid_ff;
   logic [tlbcr_pkg::ENTRIES-1:0]      ref_ff;
   logic [tlbcr_pkg::PAGE_BITS-1:0]    page_ff [tlbcr_pkg::ENTRIES];
   logic [tlbcr_pkg::FRAME_BITS-1:0]   frame_mem [tlbcr_pkg::ENTRIES];
   logic [tlbcr_pkg::SLOT_BITS-1:0]    hand_ff;
   logic [tlbcr_pkg::SLOT_BITS-1:0]    hand_in;
   logic [tlbcr_pkg::COUNT_BITS-1:0]   free_ff;

   // per-request working registers
   logic [tlbcr_pkg::ENTRIES-1:0]      cam_hit;
   logic [tlbcr_pkg::ENTRIES-1:0]      match_ff;
   logic [tlbcr_pkg::SLOT_BITS-1:0]    slot_ff;
   logic                               hit_ff;
   logic                               repl_ff;
   logic                               from_free_ff;
   logic [tlbcr_pkg::FRAME_BITS-1:0]   found_ff;
   logic                               free_avail;

   // output register payload
   logic                               rsp_hit_ff;
   logic [tlbcr_pkg::FRAME_BITS-1:0]   rsp_found_ff;
   logic [tlbcr_pkg::SLOT_BITS-1:0]    rsp_slot_ff;
   logic                               rsp_repl_ff;

   always_comb begin
      for (int i = 0; i < tlbcr_pkg::ENTRIES; i++) begin
         cam_hit[i] = valid_ff[i] && (page_ff[i] == page_req_ff);
      end
   end

   assign free_avail = (free_ff != '0) && (|(~valid_ff));
   assign hand_in = (hand_ff == tlbcr_pkg::SLOT_BITS'(tlbcr_pkg::ENTRIES - 1)) ?
                    '0 : hand_ff + 1'b1;

   assign status.req_type    = type_ff;
   assign status.any_match   = |match_ff;
   assign status.free_avail  = free_avail;
   assign status.ref_at_hand = ref_ff[hand_ff];

   // control-relevant entry state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ref_ff   <= '0;
         hand_ff  <= '0;
         free_ff  <= tlbcr_pkg::COUNT_BITS'(tlbcr_pkg::ENTRIES);
      end else begin
         if (cmd.set_refs) ref_ff <= ref_ff | match_ff;
         if (cmd.sweep) begin
            if (ref_ff[hand_ff]) ref_ff[hand_ff] <= 1'b0;
            hand_ff <= hand_in;
         end
         if (cmd.commit) begin
            if (type_ff == tlbcr_pkg::REQ_INSERT) begin
               valid_ff[slot_ff] <= 1'b1;
               ref_ff[slot_ff]   <= 1'b1;
               if (from_free_ff) free_ff <= free_ff - 1'b1;
            end else if (type_ff == tlbcr_pkg::REQ_INVAL && hit_ff) begin
               valid_ff[slot_ff] <= 1'b0;
               ref_ff[slot_ff]   <= 1'b0;
               if (free_ff != tlbcr_pkg::COUNT_BITS'(tlbcr_pkg::ENTRIES)) begin
                  free_ff <= free_ff + 1'b1;
               end
            end
         end
      end
   end

   // payload registers and memories
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff      <= req_type;
         page_req_ff  <= page_number;
         frame_req_ff <= frame_number;
      end
      if (cmd.match) match_ff <= cam_hit;
      if (cmd.pick) begin
         hit_ff       <= ((type_ff == tlbcr_pkg::REQ_LOOKUP) ||
                          (type_ff == tlbcr_pkg::REQ_INVAL)) && (|match_ff);
         repl_ff      <= 1'b0;
         from_free_ff <= (type_ff == tlbcr_pkg::REQ_INSERT) && free_avail;
         found_ff     <= '0;
         case (type_ff)
            tlbcr_pkg::REQ_LOOKUP: slot_ff <= highest_set(match_ff);
            tlbcr_pkg::REQ_INVAL:  slot_ff <= lowest_set(match_ff);
            tlbcr_pkg::REQ_INSERT: slot_ff <= lowest_set(~valid_ff);
            default:               slot_ff <= '0;
         endcase
      end
      // victim found: bit already clear
      if (cmd.sweep && !ref_ff[hand_ff]) begin
         slot_ff <= hand_ff;
         repl_ff <= valid_ff[hand_ff];
      end
      if (cmd.read_frame) found_ff <= frame_mem[slot_ff];
      if (cmd.commit && type_ff == tlbcr_pkg::REQ_INSERT) begin
         page_ff[slot_ff]   <= page_req_ff;
         frame_mem[slot_ff] <= frame_req_ff;
      end
      if (cmd.load_rsp) begin
         rsp_hit_ff   <= hit_ff;
         rsp_found_ff <= found_ff;
         rsp_slot_ff  <= slot_ff;
         rsp_repl_ff  <= repl_ff;
      end
   end

   assign rsp_hit         = rsp_hit_ff;
   assign rsp_found_frame = rsp_found_ff;
   assign rsp_slot_used   = rsp_slot_ff;
   assign rsp_replaced    = rsp_repl_ff;

endmodule

FILE: rtl/core/tlbcr_ctrl.sv
// TLB controller: sequences match, pick, clock sweep, frame read, commit and response.
module tlbcr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  tlbcr_pkg::status_type status,
   output tlbcr_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MATCH  = 3'd1;
   localparam logic [2:0] ST_PICK   = 3'd2;
   localparam logic [2:0] ST_SWEEP  = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_COMMIT = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            case (status.req_type)
               tlbcr_pkg::REQ_LOOKUP: begin
                  cmd.set_refs = 1'b1;
                  state_in     = status.any_match ? ST_READ : ST_RESP;
               end
               tlbcr_pkg::REQ_INSERT: state_in = status.free_avail ? ST_COMMIT : ST_SWEEP;
               tlbcr_pkg::REQ_INVAL:  state_in = ST_COMMIT;
               default:               state_in = ST_RESP;
            endcase
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (!status.ref_at_hand) state_in = ST_COMMIT;
         end
         ST_READ: begin
            cmd.read_frame = 1'b1;
            state_in       = ST_RESP;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
